FILE: design/wss_pkg.sv
// shared types and constants for the waveform shaper
package wss_pkg;

  localparam logic [2:0] SHAPE_SINE     = 3'd0;
  localparam logic [2:0] SHAPE_TRIANGLE = 3'd1;
  localparam logic [2:0] SHAPE_SQUARE   = 3'd2;
  localparam logic [2:0] SHAPE_QSQUARE  = 3'd3;
  localparam logic [2:0] SHAPE_SAW      = 3'd4;

  localparam logic [15:0] ONE_Q14       = 16'sd16384;
  localparam logic [15:0] MINUS_ONE_Q14 = 16'hC000;
  localparam logic [14:0] POLY_C0       = 15'd19900;
  localparam logic [11:0] POLY_C1       = 12'd3516;
  localparam logic [12:0] Y_ONE_Q12     = 13'd4096;

  // stage 1 result: squared angle plus side info
  typedef struct packed {
    logic        sine;
    logic        neg;
    logic [15:0] alt;
    logic [14:0] s;
  } s1_t;

  // stage 2 result: adds the inner polynomial term
  typedef struct packed {
    logic        sine;
    logic        neg;
    logic [15:0] alt;
    logic [14:0] s;
    logic [14:0] t;
  } s2_t;

  // stage 3 result: q12 sine magnitude
  typedef struct packed {
    logic        sine;
    logic        neg;
    logic [15:0] alt;
    logic [12:0] y;
  } s3_t;

endpackage

FILE: design/wss_front.sv
// stage 1: angle fold, squaring and the non-sine shapes
module wss_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         waveform,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [13:0]        phase,
  output logic               out_valid,
  input  logic               out_ready,
  output wss_pkg::s1_t       out_data
);
  import wss_pkg::*;

  logic [13:0]        u;
  logic signed [27:0] sq;
  logic [15:0]        p4;
  logic [15:0]        p2;
  logic [15:0]        tri_v;
  s1_t                data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    u     = {phase[12:0], 1'b0} - 14'h2000;
    sq    = $signed(u) * $signed(u);
    p4    = {phase, 2'b00};
    p2    = {1'b0, phase, 1'b0};
    if (phase < 14'd4096) begin
      tri_v = p4;
    end else if (phase < 14'd12288) begin
      tri_v = 16'h8000 - p4;
    end else begin
      tri_v = p4;
    end
    data_next.sine = (waveform == SHAPE_SINE);
    data_next.neg  = phase[13];
    data_next.s    = sq[26:12];
    case (waveform)
      SHAPE_TRIANGLE: data_next.alt = tri_v;
      SHAPE_SQUARE:   data_next.alt = phase[13] ? MINUS_ONE_Q14 : ONE_Q14;
      SHAPE_QSQUARE:  data_next.alt = (phase < 14'd4096) ? ONE_Q14 : MINUS_ONE_Q14;
      SHAPE_SAW:      data_next.alt = ONE_Q14 - p2;
      default:        data_next.alt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: design/wss_poly.sv
// stage 2: inner polynomial term t = c0 - (s * c1 >> 14)
module wss_poly (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wss_pkg::s1_t       in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wss_pkg::s2_t       out_data
);
  import wss_pkg::*;

  logic [26:0] prod;
  s2_t         data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    prod           = 27'(in_data.s) * 27'(POLY_C1);
    data_next.sine = in_data.sine;
    data_next.neg  = in_data.neg;
    data_next.alt  = in_data.alt;
    data_next.s    = in_data.s;
    data_next.t    = POLY_C0 - {3'b000, prod[25:14]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: design/wss_mag.sv
// stage 3: q12 magnitude y = 4096 - (s * t >> 16)
module wss_mag (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wss_pkg::s2_t       in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wss_pkg::s3_t       out_data
);
  import wss_pkg::*;

  logic [29:0] prod;
  s3_t         data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    prod           = 30'(in_data.s) * 30'(in_data.t);
    data_next.sine = in_data.sine;
    data_next.neg  = in_data.neg;
    data_next.alt  = in_data.alt;
    data_next.y    = Y_ONE_Q12 - prod[28:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: design/waveform_shaper_q14_core.sv
// top level of the q14 waveform shaper: shape register, pipeline and output register
//
// usage:
//   s_tvalid/s_tready/s_tdata carry one phase per transfer (0..16383 is one period).
//   m_tvalid/m_tready/m_tdata carry one signed q14 sample per input transfer,
//   in input order, in the range -16384..16384.
//   waveform_we/waveform_wdata write the shape select (0 sine, 1 triangle,
//   2 square, 3 quarter square, 4 saw, other codes give 0); write it only
//   while no transfer is in flight.
// pipeline: three compute stages and the output register, one multiplier per
//   stage. throughput: one transfer per cycle while m_tready is high; each
//   stage has its own valid bit and takes a new item whenever it is empty
//   or its successor takes its item.
// stall: when m_tready is low the output holds, filled stages stop and
//   empty stages ahead of them keep filling, so s_tready drops only when
//   all four stages are full. nothing is lost or repeated.
// reset: rst clears all valid bits and sets the shape to sine.
module waveform_shaper_q14_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        waveform_we,
  input  logic [2:0]  waveform_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [13:0] phase, [15:14] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [15:0] sample
);
  import wss_pkg::*;

  logic [2:0]  waveform;
  logic        v1;
  logic        v2;
  logic        v3;
  logic        r2;
  logic        r3;
  logic        r4;
  s1_t         d1;
  s2_t         d2;
  s3_t         d3;
  logic [15:0] mag;
  logic [15:0] sample_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform <= SHAPE_SINE;
    end else if (waveform_we) begin
      waveform <= waveform_wdata;
    end
  end

  wss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .waveform  (waveform),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .phase     (s_tdata[13:0]),
    .out_valid (v1),
    .out_ready (r2),
    .out_data  (d1)
  );

  wss_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r2),
    .in_data   (d1),
    .out_valid (v2),
    .out_ready (r3),
    .out_data  (d2)
  );

  wss_mag u_mag (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r3),
    .in_data   (d2),
    .out_valid (v3),
    .out_ready (r4),
    .out_data  (d3)
  );

  assign r4 = !m_tvalid || m_tready;

  always_comb begin
    mag = {1'b0, d3.y, 2'b00};
    if (d3.sine) begin
      sample_next = d3.neg ? (16'd0 - mag) : mag;
    end else begin
      sample_next = d3.alt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (r4) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      m_tdata <= sample_next;
    end
  end

  // output stays within plus and minus one
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata) <= 16'sd16384 && $signed(m_tdata) >= -16'sd16384))
    else $error("sample out of range");

  // an empty output register means every stage can take a transfer
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // sine magnitude never exceeds one in q12
  assert property (@(posedge clk) disable iff (rst) (v3 && d3.sine) |-> d3.y <= Y_ONE_Q12)
    else $error("sine magnitude overflow");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule
